/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. All checks sample on clk and are
// disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/sarp_pkg.sv */
`timescale 1ns / 1ps
package sarp_pkg;

	// Default number of table entries
	localparam int TABLE_DEPTH_DEF = 64;

	// Table entry: servo id, target position, move time
	localparam int ID_W    = 8;
	localparam int POS_W   = 16;
	localparam int MS_W    = 16;
	localparam int ENTRY_W = ID_W + POS_W + MS_W;
	localparam int TIME_W  = 32;
	localparam int CNT_OUT_W = 7;

	// Extra settle time after a reset-all command
	localparam logic [TIME_W-1:0] RESET_GUARD_MS = 32'd50;

	// Configuration register
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_IDX_RESET_ID = 1'b0;
	localparam logic [ID_W-1:0] RESET_ID_DEF = 8'hFF;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_RECORD    = 3'd1,
		OP_REC_START = 3'd2,
		OP_REC_STOP  = 3'd3,
		OP_PLAY      = 3'd4,
		OP_CLEAR     = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_BUSY      = 3'd2,
		ST_ALREADY   = 3'd3,
		ST_NOT_REC   = 3'd4,
		ST_EMPTY     = 3'd5,
		ST_FINISHED  = 3'd6
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [POS_W-1:0] pos;
		logic [MS_W-1:0]  ms;
	} entry_t;

endpackage

/* rtl/sarp_ram.sv */
`timescale 1ns / 1ps
module sarp_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/servo_action_record_playback.sv */
`timescale 1ns / 1ps
// Servo action record and playback.
// Input channel (in_valid/in_ready) carries one command beat: opcode, servo_id,
// target_position, move_duration and servos_moving. Each command beat yields
// exactly one result beat on the output channel (out_valid/out_ready) with the
// status, any issued move or reset-all command, and the mode flags and counts.
// The beat passes through the input stage, where the action table read for the
// next play entry lands, and then the result register, which drives out_valid.
// Throughput is one beat per cycle while the receiver takes results; the table
// is a single-port-write, registered-read memory read once per accepted beat.
// The result register frees the input stage, so a new beat is taken while a
// result waits; when the receiver stalls with a full result register and a
// full input stage, in_ready drops until out_ready returns.
// Reset clears modes, counts and both clocks and sets the reset-all servo id
// to 255; table contents are not cleared and are only read below the count.
// The reset-all id register sits at APB byte address 0; pready is always high.
module servo_action_record_playback #(
	parameter int TABLE_DEPTH = sarp_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sarp_pkg::PADDR_W-1:0]  paddr,
	input  logic [sarp_pkg::PDATA_W-1:0]  pwdata,
	output logic [sarp_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	// Command channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    opcode,
	input  logic [sarp_pkg::ID_W-1:0]     servo_id,
	input  logic [sarp_pkg::POS_W-1:0]    target_position,
	input  logic [sarp_pkg::MS_W-1:0]     move_duration,
	input  logic                          servos_moving,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic                          issue_move,
	output logic                          issue_reset_all,
	output logic [sarp_pkg::ID_W-1:0]     cmd_servo,
	output logic [sarp_pkg::POS_W-1:0]    cmd_position,
	output logic [sarp_pkg::MS_W-1:0]     cmd_duration,
	output logic                          recording_flag,
	output logic                          playing_flag,
	output logic [sarp_pkg::CNT_OUT_W-1:0] stored_count,
	output logic [sarp_pkg::CNT_OUT_W-1:0] play_position,
	output logic                          status_changed
);

	import sarp_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

	// Configuration register
	logic [ID_W-1:0] reset_id_q;

	// Architectural state
	logic [CW-1:0]     total_q, total_nxt;
	logic [CW-1:0]     pidx_q, pidx_nxt;
	logic              recording_q, recording_nxt;
	logic              playing_q, playing_nxt;
	logic [TIME_W-1:0] now_q, now_nxt;
	logic [TIME_W-1:0] due_q, due_nxt;

	// Input stage
	logic              valid_s1;
	logic [2:0]        opcode_s1;
	logic [ID_W-1:0]   servo_id_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [MS_W-1:0]   dur_s1;
	logic              moving_s1;
	logic              byp_hit_s1;
	entry_t            byp_data_s1;

	// Result register
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic              mv_q, rst_q, changed_q;
	entry_t            cmd_q;
	logic              rec_out_q, play_out_q;
	logic [CW-1:0]     total_out_q, pidx_out_q;

	// Step results
	status_t           st;
	logic              mv, rst, changed;
	entry_t            cmd;
	logic              wr_en;
	entry_t            wr_data;
	entry_t            rd_entry;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [AW-1:0]     rd_addr;
	logic              advance, fire, in_acc;
	logic [TIME_W-1:0] tick_now;

	// Counts shown on the port: low bits, zero extended
	logic [CW+CNT_OUT_W-1:0] total_ext, pidx_ext;

	// Handshake
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign in_acc   = in_valid && in_ready;

	// APB register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDX_RESET_ID) ? PDATA_W'(reset_id_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_id_q <= RESET_ID_DEF;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_RESET_ID) begin
			reset_id_q <= pwdata[ID_W-1:0];
		end
	end

	// Pick the fresher of table read and same-cycle write
	assign rd_entry = byp_hit_s1 ? byp_data_s1 : entry_t'(ram_rdata);
	assign tick_now = now_q + TIME_W'(1);

	// Step logic: one command against the current state
	always_comb begin
		total_nxt     = total_q;
		pidx_nxt      = pidx_q;
		recording_nxt = recording_q;
		playing_nxt   = playing_q;
		now_nxt       = now_q;
		due_nxt       = due_q;
		st            = ST_OK;
		mv            = 1'b0;
		rst           = 1'b0;
		changed       = 1'b0;
		cmd           = '0;
		wr_en         = 1'b0;
		wr_data       = '{id: servo_id_s1, pos: pos_s1, ms: dur_s1};
		if (fire) begin
			case (op_t'(opcode_s1))
				OP_TICK: begin
					now_nxt = tick_now;
					if (playing_q) begin
						if (pidx_q >= total_q) begin
							playing_nxt = 1'b0;
							st          = ST_FINISHED;
							changed     = 1'b1;
						end else if (tick_now >= due_q && !moving_s1) begin
							cmd = rd_entry;
							if (rd_entry.id == reset_id_q) begin
								rst     = 1'b1;
								due_nxt = tick_now + TIME_W'(rd_entry.ms) + RESET_GUARD_MS;
							end else begin
								mv      = 1'b1;
								due_nxt = tick_now + TIME_W'(rd_entry.ms);
							end
							pidx_nxt = pidx_q + CW'(1);
							changed  = 1'b1;
						end
					end
				end
				OP_RECORD: begin
					if (total_q >= DEPTH_CNT) begin
						st = ST_FULL;
					end else begin
						wr_en     = 1'b1;
						total_nxt = total_q + CW'(1);
					end
				end
				OP_REC_START: begin
					if (playing_q) begin
						st = ST_BUSY;
					end else if (recording_q) begin
						st = ST_ALREADY;
					end else begin
						total_nxt     = '0;
						recording_nxt = 1'b1;
						changed       = 1'b1;
					end
				end
				OP_REC_STOP: begin
					if (!recording_q) begin
						st = ST_NOT_REC;
					end else begin
						recording_nxt = 1'b0;
						changed       = 1'b1;
					end
				end
				OP_PLAY: begin
					if (recording_q) begin
						st = ST_BUSY;
					end else if (playing_q) begin
						st = ST_ALREADY;
					end else if (total_q == '0) begin
						st = ST_EMPTY;
					end else begin
						playing_nxt = 1'b1;
						pidx_nxt    = '0;
						due_nxt     = now_q;
						changed     = 1'b1;
					end
				end
				OP_CLEAR: begin
					total_nxt = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Read the entry the next command would play
	assign rd_addr = pidx_nxt[AW-1:0];

	sarp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (total_q[AW-1:0]),
		.wdata (wr_data),
		.re    (in_acc),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			pidx_q      <= '0;
			recording_q <= 1'b0;
			playing_q   <= 1'b0;
			now_q       <= '0;
			due_q       <= '0;
		end else begin
			total_q     <= total_nxt;
			pidx_q      <= pidx_nxt;
			recording_q <= recording_nxt;
			playing_q   <= playing_nxt;
			now_q       <= now_nxt;
			due_q       <= due_nxt;
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload and write bypass
	always_ff @(posedge clk) begin
		if (in_acc) begin
			opcode_s1   <= opcode;
			servo_id_s1 <= servo_id;
			pos_s1      <= target_position;
			dur_s1      <= move_duration;
			moving_s1   <= servos_moving;
			byp_hit_s1  <= wr_en && (total_q[AW-1:0] == rd_addr);
			byp_data_s1 <= wr_data;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= st;
			mv_q        <= mv;
			rst_q       <= rst;
			changed_q   <= changed;
			cmd_q       <= cmd;
			rec_out_q   <= recording_nxt;
			play_out_q  <= playing_nxt;
			total_out_q <= total_nxt;
			pidx_out_q  <= pidx_nxt;
		end
	end

	assign total_ext = {{CNT_OUT_W{1'b0}}, total_out_q};
	assign pidx_ext  = {{CNT_OUT_W{1'b0}}, pidx_out_q};

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign issue_move      = mv_q;
	assign issue_reset_all = rst_q;
	assign cmd_servo       = cmd_q.id;
	assign cmd_position    = cmd_q.pos;
	assign cmd_duration    = cmd_q.ms;
	assign recording_flag  = rec_out_q;
	assign playing_flag    = play_out_q;
	assign stored_count    = total_ext[CNT_OUT_W-1:0];
	assign play_position   = pidx_ext[CNT_OUT_W-1:0];
	assign status_changed  = changed_q;

	// Checks
`include "assert_macros.svh"

	`ASSERT_SAME(a_modes_exclusive, 1'b1, !(recording_q && playing_q))
	`ASSERT_SAME(a_total_bound, 1'b1, total_q <= DEPTH_CNT)
	`ASSERT_NEXT(a_stage_holds, valid_s1 && !advance, valid_s1)
	`ASSERT_SAME(a_issue_flags, out_valid_q && (mv_q || rst_q), changed_q && !(mv_q && rst_q))

endmodule

/* sim/tb_servo_action_record_playback.sv */
`timescale 1ns / 1ps
module tb_servo_action_record_playback;
	import sarp_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1650;
	localparam int PHASES = 4;
	localparam int LONG_HOLD = 60;
	localparam int TICK_CAP = 600;
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam logic [PADDR_W-1:0] RESET_ID_ADDR = PADDR_W'(4 * int'(REG_IDX_RESET_ID));

	typedef struct packed {
		logic [2:0]           status;
		logic                 issue_move;
		logic                 issue_reset_all;
		logic [ID_W-1:0]      cmd_servo;
		logic [POS_W-1:0]     cmd_position;
		logic [MS_W-1:0]      cmd_duration;
		logic                 recording;
		logic                 playing;
		logic [CNT_OUT_W-1:0] stored;
		logic [CNT_OUT_W-1:0] position;
		logic                 changed;
	} servo_result_t;

	// Playback predictor and queue of expected result beats
	class servo_playback_scoreboard;
		entry_t          actions[DEPTH];
		int unsigned     total;
		int unsigned     pidx;
		bit              recording;
		bit              playing;
		bit [31:0]       now_ms;
		bit [31:0]       due_ms;
		bit [7:0]        reset_id;
		servo_result_t   expected_q[$];
		int              errors;

		function new();
			total = 0;
			pidx = 0;
			recording = 0;
			playing = 0;
			now_ms = 0;
			due_ms = 0;
			reset_id = RESET_ID_DEF;
			errors = 0;
		endfunction

		function void set_reset_id(logic [7:0] id);
			reset_id = id;
		endfunction

		// Advance the state by one accepted command beat and queue its result
		function void note_input(logic [2:0] op, logic [7:0] sid, logic [15:0] pos,
				logic [15:0] dur, logic mov);
			servo_result_t r;
			entry_t e;
			r = '0;
			case (op)
				OP_TICK: begin
					now_ms = now_ms + 32'd1;
					if (playing) begin
						if (pidx >= total) begin
							playing = 0;
							r.status = ST_FINISHED;
							r.changed = 1;
						end else if (now_ms >= due_ms && !mov) begin
							e = actions[pidx % DEPTH];
							r.cmd_servo = e.id;
							r.cmd_position = e.pos;
							r.cmd_duration = e.ms;
							if (e.id == reset_id) begin
								r.issue_reset_all = 1;
								due_ms = now_ms + {16'd0, e.ms} + RESET_GUARD_MS;
							end else begin
								r.issue_move = 1;
								due_ms = now_ms + {16'd0, e.ms};
							end
							pidx++;
							r.changed = 1;
						end
					end
				end
				OP_RECORD: begin
					if (total >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						actions[total] = '{id: sid, pos: pos, ms: dur};
						total++;
					end
				end
				OP_REC_START: begin
					if (playing) begin
						r.status = ST_BUSY;
					end else if (recording) begin
						r.status = ST_ALREADY;
					end else begin
						total = 0;
						recording = 1;
						r.changed = 1;
					end
				end
				OP_REC_STOP: begin
					if (!recording) begin
						r.status = ST_NOT_REC;
					end else begin
						recording = 0;
						r.changed = 1;
					end
				end
				OP_PLAY: begin
					if (recording) begin
						r.status = ST_BUSY;
					end else if (playing) begin
						r.status = ST_ALREADY;
					end else if (total == 0) begin
						r.status = ST_EMPTY;
					end else begin
						playing = 1;
						pidx = 0;
						due_ms = now_ms;
						r.changed = 1;
					end
				end
				OP_CLEAR: begin
					total = 0;
				end
				default: ;
			endcase
			r.recording = recording;
			r.playing = playing;
			r.stored = total[CNT_OUT_W-1:0];
			r.position = pidx[CNT_OUT_W-1:0];
			expected_q.push_back(r);
		endfunction

		function void check_field(string name, logic [31:0] exp, logic [31:0] act);
			if (act !== exp) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
			end
		endfunction

		// Compare one result beat against the oldest expectation
		function void check_result(servo_result_t got);
			servo_result_t exp;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat: expected none, actual %0h", $time, got);
				return;
			end
			exp = expected_q.pop_front();
			check_field("status", 32'(exp.status), 32'(got.status));
			check_field("issue_move", 32'(exp.issue_move), 32'(got.issue_move));
			check_field("issue_reset_all", 32'(exp.issue_reset_all),
				32'(got.issue_reset_all));
			check_field("cmd_servo", 32'(exp.cmd_servo), 32'(got.cmd_servo));
			check_field("cmd_position", 32'(exp.cmd_position), 32'(got.cmd_position));
			check_field("cmd_duration", 32'(exp.cmd_duration), 32'(got.cmd_duration));
			check_field("recording_flag", 32'(exp.recording), 32'(got.recording));
			check_field("playing_flag", 32'(exp.playing), 32'(got.playing));
			check_field("stored_count", 32'(exp.stored), 32'(got.stored));
			check_field("play_position", 32'(exp.position), 32'(got.position));
			check_field("status_changed", 32'(exp.changed), 32'(got.changed));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic [2:0]           opcode;
	logic [ID_W-1:0]      servo_id;
	logic [POS_W-1:0]     target_position;
	logic [MS_W-1:0]      move_duration;
	logic                 servos_moving;
	logic                 out_valid;
	logic                 out_ready;
	logic [2:0]           status;
	logic                 issue_move;
	logic                 issue_reset_all;
	logic [ID_W-1:0]      cmd_servo;
	logic [POS_W-1:0]     cmd_position;
	logic [MS_W-1:0]      cmd_duration;
	logic                 recording_flag;
	logic                 playing_flag;
	logic [CNT_OUT_W-1:0] stored_count;
	logic [CNT_OUT_W-1:0] play_position;
	logic                 status_changed;

	servo_playback_scoreboard sb = new();
	int send_idle_pct;
	int recv_stall_pct;
	bit long_hold_req;
	int items_sent;
	int cycle_cnt;

	servo_action_record_playback dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.servo_id        (servo_id),
		.target_position (target_position),
		.move_duration   (move_duration),
		.servos_moving   (servos_moving),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.issue_move      (issue_move),
		.issue_reset_all (issue_reset_all),
		.cmd_servo       (cmd_servo),
		.cmd_position    (cmd_position),
		.cmd_duration    (cmd_duration),
		.recording_flag  (recording_flag),
		.playing_flag    (playing_flag),
		.stored_count    (stored_count),
		.play_position   (play_position),
		.status_changed  (status_changed)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Stop the run if it hangs
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Check every result beat
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{status: status, issue_move: issue_move,
				issue_reset_all: issue_reset_all, cmd_servo: cmd_servo,
				cmd_position: cmd_position, cmd_duration: cmd_duration,
				recording: recording_flag, playing: playing_flag,
				stored: stored_count, position: play_position,
				changed: status_changed});
	end

	// Drive out_ready: random stalls, plus one long hold when requested
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				out_ready = 0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold_req = 0;
			end else begin
				out_ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic cfg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic write_reset_id(logic [7:0] id);
		cfg_write(RESET_ID_ADDR, {24'($urandom()), id});
		sb.set_reset_id(id);
	endtask

	// Offer one command beat, hold it until accepted, then note it
	task automatic send_cmd(logic [2:0] op, logic [7:0] sid, logic [15:0] pos,
			logic [15:0] dur, logic mov);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		opcode = op;
		servo_id = sid;
		target_position = pos;
		move_duration = dur;
		servos_moving = mov;
		do @(posedge clk); while (!in_ready);
		sb.note_input(op, sid, pos, dur, mov);
		if (op <= OP_CLEAR)
			items_sent++;
	endtask

	task automatic send_op(logic [2:0] op);
		send_cmd(op, 8'($urandom()), 16'($urandom()), 16'($urandom()), 1'($urandom()));
	endtask

	task automatic send_noise();
		send_op(3'($urandom_range(0, 7)));
	endtask

	// Drop the last beat from the input, then let every result come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Mostly short durations so playback runs through; a few long ones
	function automatic logic [15:0] pick_duration();
		int k;
		k = $urandom_range(99);
		if (k < 85)
			return 16'($urandom_range(0, 6));
		else if (k < 97)
			return 16'($urandom_range(0, 80));
		return 16'($urandom());
	endfunction

	function automatic logic [7:0] pick_servo();
		if ($urandom_range(99) < 25)
			return sb.reset_id;
		return 8'($urandom_range(0, 255));
	endfunction

	// Record a set, play it back to the end, abort with clear if it drags on; otherwise send noise beats
	task automatic run_session();
		int n;
		int ticks;
		if ($urandom_range(99) < 80) begin
			send_op(OP_REC_START);
			n = ($urandom_range(99) < 10) ? $urandom_range(60, 70) : $urandom_range(1, 6);
			repeat (n) send_cmd(OP_RECORD, pick_servo(), 16'($urandom()), pick_duration(),
				1'($urandom()));
			if ($urandom_range(99) < 90)
				send_op(OP_REC_STOP);
			send_op(OP_PLAY);
			ticks = 0;
			while (sb.playing && ticks < TICK_CAP) begin
				if ($urandom_range(99) < 4)
					send_noise();
				else
					send_cmd(OP_TICK, 8'($urandom()), 16'($urandom()), 16'($urandom()),
						$urandom_range(99) < 25);
				ticks++;
			end
			if (sb.playing) begin
				send_op(OP_CLEAR);
				send_cmd(OP_TICK, 8'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0);
			end
		end else begin
			repeat ($urandom_range(1, 4)) send_noise();
		end
	endtask

	task automatic run_directed();
		send_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_REC_STOP, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_PLAY, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_REC_START, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_REC_START, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_cmd(OP_RECORD, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_RECORD, 8'hFF, 16'hFFFF, 16'h0001, 1'b1);
		// play while recording, stop twice, play twice, record start while playing
		send_cmd(OP_PLAY, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_REC_STOP, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_REC_STOP, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_PLAY, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_PLAY, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_REC_START, 8'h00, 16'h0000, 16'h0000, 1'b0);
		// servos busy, then a move, then a reset-all
		send_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b1);
		send_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
		// clear during playback ends it on the next tick
		send_cmd(OP_CLEAR, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_cmd(OP_SPARE_LO, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_cmd(OP_SPARE_HI, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_cmd(OP_RECORD, 8'hAA, 16'h5555, 16'hFFFF, 1'b0);
		send_cmd(OP_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_cmd(OP_PLAY, 8'h00, 16'h0000, 16'h0000, 1'b0);
	endtask

	initial begin
		int quota;
		logic [7:0] phase_id [PHASES];
		int phase_idle [PHASES];
		int phase_stall [PHASES];
		phase_id = '{8'h00, 8'($urandom()), 8'hFF, 8'($urandom())};
		phase_idle = '{0, 50, 0, 10};
		phase_stall = '{0, 0, 50, 10};
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		in_valid = 0;
		opcode = OP_TICK;
		servo_id = '0;
		target_position = '0;
		move_duration = '0;
		servos_moving = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		long_hold_req = 0;
		items_sent = 0;
		cycle_cnt = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		write_reset_id(RESET_ID_DEF);
		run_directed();

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_reset_id(phase_id[p]);
			send_idle_pct = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			// Hold the receiver off while beats keep coming so the block backs up
			if (p == 0)
				long_hold_req = 1;
			quota = items_sent + ITEM_TARGET / PHASES;
			while (items_sent < quota)
				run_session();
		end

		@(negedge clk);
		in_valid = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
